/* design/assert_macros.svh */
// Assertion helpers shared by the blit engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CLBB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define CLBB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/clbb_pkg.sv */
package clbb_pkg;

    localparam int unsigned PIXEL_W  = 8;
    localparam int unsigned ADDR_W   = 19;
    localparam int unsigned COORD_W  = 11;
    localparam int unsigned SCR_W    = 12;
    localparam int unsigned COL_W    = 9;
    localparam int unsigned ROW_W    = 8;
    localparam int unsigned PLANE_W  = 2;
    localparam int unsigned LWIDTH_W = 11;
    localparam int unsigned BASE_W   = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned PLANE_STEP = 4;
    localparam int unsigned M_TDATA_W  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEST_X      = 3'd0,
        REG_DEST_Y      = 3'd1,
        REG_BLIT_WIDTH  = 3'd2,
        REG_BLIT_HEIGHT = 3'd3,
        REG_BLIT_MODE   = 3'd4,
        REG_GLYPH_COLOR = 3'd5,
        REG_FRAME_BASE  = 3'd6,
        REG_LINE_WIDTH  = 3'd7
    } cfg_idx_t;

    localparam logic [1:0] MODE_PLANAR = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_GLYPH  = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0]  dest_x;
        logic [COORD_W-1:0]  dest_y;
        logic [COL_W-1:0]    blit_width;
        logic [ROW_W-1:0]    blit_height;
        logic [1:0]          blit_mode;
        logic [PIXEL_W-1:0]  glyph_color;
        logic [BASE_W-1:0]   frame_base;
        logic [LWIDTH_W-1:0] line_width;
    } cfg_t;

    // Stage one beat: pixel with its screen position already resolved.
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [SCR_W-1:0]   sx;
        logic [SCR_W-1:0]   sy;
        logic               done;
    } pos_t;

endpackage

/* design/clbb_cfg.sv */
module clbb_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [clbb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [clbb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output clbb_pkg::cfg_t                     cfg
);
    import clbb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                REG_DEST_X:      cfg_next.dest_x      = cfg_wdata[COORD_W-1:0];
                REG_DEST_Y:      cfg_next.dest_y      = cfg_wdata[COORD_W-1:0];
                REG_BLIT_WIDTH:  cfg_next.blit_width  = cfg_wdata[COL_W-1:0];
                REG_BLIT_HEIGHT: cfg_next.blit_height = cfg_wdata[ROW_W-1:0];
                REG_BLIT_MODE:   cfg_next.blit_mode   = cfg_wdata[1:0];
                REG_GLYPH_COLOR: cfg_next.glyph_color = cfg_wdata[PIXEL_W-1:0];
                REG_FRAME_BASE:  cfg_next.frame_base  = cfg_wdata[BASE_W-1:0];
                REG_LINE_WIDTH:  cfg_next.line_width  = cfg_wdata[LWIDTH_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dest_x      <= '0;
            cfg_reg.dest_y      <= '0;
            cfg_reg.blit_width  <= COL_W'(1);
            cfg_reg.blit_height <= ROW_W'(1);
            cfg_reg.blit_mode   <= MODE_PLANAR;
            cfg_reg.glyph_color <= '0;
            cfg_reg.frame_base  <= '0;
            cfg_reg.line_width  <= LWIDTH_W'(320);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/clbb_walk.sv */
`include "assert_macros.svh"

module clbb_walk (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  clbb_pkg::cfg_t                cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [clbb_pkg::PIXEL_W-1:0]  s_pixel,
    input  logic                          s1_take,
    output logic                          s1_valid,
    output clbb_pkg::pos_t                s1_pos
);
    import clbb_pkg::*;

    logic [PLANE_W-1:0] plane_reg, plane_next;
    logic [ROW_W-1:0]   row_reg,   row_next;
    logic [COL_W-1:0]   col_reg,   col_next;
    logic               s1_valid_reg, s1_valid_next;
    pos_t               s1_reg;

    logic               accept;
    logic [COL_W-1:0]   w;
    logic [ROW_W-1:0]   h;
    logic [COL_W:0]     nc;
    logic [ROW_W:0]     nr;
    logic [PLANE_W:0]   np;
    logic               done;
    pos_t               pos;

    assign s_tready = !s1_valid_reg || s1_take;
    assign accept   = s_tvalid && s_tready;

    assign w = (cfg.blit_width == '0) ? COL_W'(1) : cfg.blit_width;
    assign h = (cfg.blit_height == '0) ? ROW_W'(1) : cfg.blit_height;

    always_comb begin
        plane_next = plane_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        done       = 1'b0;
        nr = {1'b0, row_reg} + (ROW_W+1)'(1);
        np = {1'b0, plane_reg} + (PLANE_W+1)'(1);
        if (cfg.blit_mode == MODE_PLANAR) begin
            nc = {1'b0, col_reg} + (COL_W+1)'(PLANE_STEP);
        end else begin
            nc = {1'b0, col_reg} + (COL_W+1)'(1);
        end
        if (nc < {1'b0, w}) begin
            col_next = nc[COL_W-1:0];
        end else if (nr < {1'b0, h}) begin
            row_next = nr[ROW_W-1:0];
            col_next = (cfg.blit_mode == MODE_PLANAR) ? COL_W'(plane_reg) : '0;
        end else if (cfg.blit_mode == MODE_PLANAR && !np[PLANE_W]
                     && (COL_W'(np) < w)) begin
            // Next plane has columns: restart at its first column.
            plane_next = np[PLANE_W-1:0];
            row_next   = '0;
            col_next   = COL_W'(np);
        end else begin
            plane_next = '0;
            row_next   = '0;
            col_next   = '0;
            done       = 1'b1;
        end
    end

    always_comb begin
        pos.pixel = s_pixel;
        pos.sx    = {cfg.dest_x[COORD_W-1], cfg.dest_x} + SCR_W'(col_reg);
        pos.sy    = {cfg.dest_y[COORD_W-1], cfg.dest_y} + SCR_W'(row_reg);
        pos.done  = done;
    end

    assign s1_valid_next = accept || (s1_valid_reg && !s1_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg    <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (accept) begin
                plane_reg <= plane_next;
                row_reg   <= row_next;
                col_reg   <= col_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= pos;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_pos   = s1_reg;

    `CLBB_ASSERT_NEXT(a_done_rewinds, accept && done,
        plane_reg == '0 && row_reg == '0 && col_reg == '0,
        "counters not rewound after last beat")
    `CLBB_ASSERT_NEXT(a_s1_holds, s1_valid_reg && !s1_take,
        s1_valid_reg && $stable(s1_reg), "stage one beat lost while stalled")

endmodule

/* design/clbb_wr.sv */
`include "assert_macros.svh"

module clbb_wr #(
    parameter int unsigned SCREEN_WIDTH  = 320,
    parameter int unsigned SCREEN_HEIGHT = 200
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  clbb_pkg::cfg_t                cfg,
    input  logic                          s1_valid,
    input  clbb_pkg::pos_t                s1_pos,
    output logic                          s1_take,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          m_we,
    output logic [clbb_pkg::ADDR_W-1:0]   m_addr,
    output logic [clbb_pkg::PIXEL_W-1:0]  m_data,
    output logic                          m_done
);
    import clbb_pkg::*;

    localparam logic [SCR_W-1:0] SCR_X_LIM = SCR_W'(SCREEN_WIDTH);
    localparam logic [SCR_W-1:0] SCR_Y_LIM = SCR_W'(SCREEN_HEIGHT);

    logic                  valid_reg, valid_next;
    logic                  we_reg, done_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [PIXEL_W-1:0]    data_reg;

    logic                  onscreen;
    logic                  we;
    logic signed [2*SCR_W-1:0] prod;
    logic [ADDR_W-1:0]     addr;
    logic [PIXEL_W-1:0]    data;
    logic                  load;

    // Coordinates are non-negative when the sign bit is clear.
    assign onscreen = !s1_pos.sx[SCR_W-1] && (s1_pos.sx < SCR_X_LIM)
                   && !s1_pos.sy[SCR_W-1] && (s1_pos.sy < SCR_Y_LIM);

    assign prod = $signed(s1_pos.sy) * $signed({1'b0, cfg.line_width});
    assign addr = prod[ADDR_W-1:0]
                + {{(ADDR_W-SCR_W){s1_pos.sx[SCR_W-1]}}, s1_pos.sx}
                + ADDR_W'(cfg.frame_base);

    always_comb begin
        if (cfg.blit_mode == MODE_GLYPH) begin
            we   = onscreen && (s1_pos.pixel != '0);
            data = cfg.glyph_color;
        end else begin
            we   = onscreen;
            data = s1_pos.pixel;
        end
    end

    assign s1_take    = !valid_reg || m_tready;
    assign load       = s1_valid && s1_take;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            we_reg   <= we;
            addr_reg <= addr;
            data_reg <= data;
            done_reg <= s1_pos.done;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_we     = we_reg;
    assign m_addr   = addr_reg;
    assign m_data   = data_reg;
    assign m_done   = done_reg;

    `CLBB_ASSERT_NEXT(a_load_shows, load, valid_reg,
        "stage one beat taken but no result presented")
    `CLBB_ASSERT_NEXT(a_drain_empty, !s1_valid && (m_tready || !valid_reg), !valid_reg,
        "result presented with nothing loaded")

endmodule

/* design/clipped_bitmap_blit_engine_unit.sv */
// Channel   Dir  Bits (lowest first)
// s_        in   tdata: pixel[7:0]
// m_        out  tdata: write_address[18:0], write_data[26:19], zero[31:27];
//                tuser: write_enable; tlast: blit_done
// cfg_      in   cfg_index selects register, cfg_wdata[15:0]
//
// One pixel is taken every cycle while m_tready is high; each passes the stage one register, then the result register.
// The position counters advance on the input beat; the address multiply sits
// in the second stage ahead of the result register.
// A stalled m_tready fills both stages, then drops s_tready.
// aresetn is synchronous; it rewinds the counters and loads register defaults.
module clipped_bitmap_blit_engine_unit #(
    parameter int unsigned SCREEN_WIDTH  = 320,
    parameter int unsigned SCREEN_HEIGHT = 200
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [clbb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clbb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [clbb_pkg::PIXEL_W-1:0]        s_tdata,   // pixel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [clbb_pkg::M_TDATA_W-1:0]      m_tdata,   // write_address, write_data
    output logic                                m_tuser,   // write_enable
    output logic                                m_tlast
);
    import clbb_pkg::*;

    cfg_t               cfg;
    logic               s1_valid;
    logic               s1_take;
    pos_t               s1_pos;
    logic               m_we;
    logic [ADDR_W-1:0]  m_addr;
    logic [PIXEL_W-1:0] m_data;
    logic               m_done;

    clbb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    clbb_walk u_walk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_pixel  (s_tdata),
        .s1_take  (s1_take),
        .s1_valid (s1_valid),
        .s1_pos   (s1_pos)
    );

    clbb_wr #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_wr (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s1_valid (s1_valid),
        .s1_pos   (s1_pos),
        .s1_take  (s1_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_we     (m_we),
        .m_addr   (m_addr),
        .m_data   (m_data),
        .m_done   (m_done)
    );

    assign m_tdata = {(M_TDATA_W-ADDR_W-PIXEL_W)'(0), m_data, m_addr};
    assign m_tuser = m_we;
    assign m_tlast = m_done;

endmodule
